### hdl/rwsp_pkg.sv
// Package for the wall slice projection block: fixed widths and the
// register map. Used by all modules in hdl/.
package rwsp_pkg;
    localparam int FRAC_BITS = 16;
    localparam int MAP_BITS  = 8;
    localparam int REG_PX = 0;
    localparam int REG_PY = 1;
    localparam int REG_H  = 2;
    localparam int REG_TW = 3;
    localparam int REG_TH = 4;
    localparam int ADDR_W = 5;
endpackage

### hdl/rwsp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses rwsp_pkg; no other dependencies.
module rwsp_div #(
    parameter int NW = 40,
    parameter int DW = 24,
    parameter int SW = 64
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);
    import rwsp_pkg::*;

    logic [NW-1:0] q_reg   [NW+1];
    logic [DW:0]   r_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic [SW-1:0] s_reg   [NW+1];

    always_comb
    begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        s_reg[0] = side_in;
    end

    for (genvar i = 0; i < NW; i++) begin : g_st
        logic [DW+1:0] sh;
        logic [DW+1:0] df;
        logic [NW-1:0] qs_reg;
        logic [DW:0]   rs_reg;
        logic [DW-1:0] ds_reg;
        logic [SW-1:0] ss_reg;
        always_comb
        begin
            sh = {r_reg[i], q_reg[i][NW-1]};
            df = sh - {2'b00, d_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!df[DW+1])
                begin
                    rs_reg <= df[DW:0];
                    qs_reg <= {q_reg[i][NW-2:0], 1'b1};
                end
                else
                begin
                    rs_reg <= sh[DW:0];
                    qs_reg <= {q_reg[i][NW-2:0], 1'b0};
                end
                ds_reg <= d_reg[i];
                ss_reg <= s_reg[i];
            end
        end
        always_comb
        begin
            q_reg[i+1] = qs_reg;
            r_reg[i+1] = rs_reg;
            d_reg[i+1] = ds_reg;
            s_reg[i+1] = ss_reg;
        end
    end

    assign quo      = q_reg[NW];
    assign side_out = s_reg[NW];
endmodule

### hdl/raycast_wall_slice_params_unit.sv
// Top level of the wall slice projection block: register port, three
// chained pipelined dividers and the finishing stages. Uses rwsp_pkg, rwsp_div.
//
//  port group | dir | meaning
//  in_*       | in  | dir_x dir_y cell_x cell_y hit_side, valid/ready
//  out_*      | out | slice results, valid/ready
//  p*         | in  | APB register writes and reads
//
// Pipeline depth is set mostly by the three bit-per-stage dividers in series;
// one item enters every cycle while the output is not stalled.
// Reset clears the valid bits and loads register defaults.
// A stall on the output freezes the whole pipeline; nothing is lost.
module raycast_wall_slice_params_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [rwsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [rwsp_pkg::FRAC_BITS+1:0] dir_x,
    input  logic signed [rwsp_pkg::FRAC_BITS+1:0] dir_y,
    input  logic [rwsp_pkg::MAP_BITS-1:0] cell_x,
    input  logic [rwsp_pkg::MAP_BITS-1:0] cell_y,
    input  logic                    hit_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [rwsp_pkg::MAP_BITS+rwsp_pkg::FRAC_BITS-1:0] wall_distance,
    output logic [15:0]             slice_rows,
    output logic [11:0]             row_first,
    output logic [11:0]             row_last,
    output logic [1:0]              texture_index,
    output logic [11:0]             texture_column,
    output logic [rwsp_pkg::FRAC_BITS+11:0] texture_step,
    output logic [rwsp_pkg::FRAC_BITS+11:0] texture_start,
    output logic                    divide_flag
);
    import rwsp_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int PW = MAP_BITS + FRAC_BITS;
    localparam int DW = F + 2;
    localparam int TW = F + 12;
    localparam int N1 = PW + F;         // distance numerator width
    localparam int N2 = 12 + F;         // height numerators
    localparam int LAT = N1 + 2*N2 + 6;

    // registers
    logic [PW-1:0] px_reg, py_reg;
    logic [11:0]   h_reg, tw_reg, th_reg;
    logic          wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            h_reg  <= 12'd480;
            tw_reg <= 12'd64;
            th_reg <= 12'd64;
        end
        else if (wr)
        begin
            case (paddr)
                ADDR_W'(4*REG_PX): px_reg <= pwdata[PW-1:0];
                ADDR_W'(4*REG_PY): py_reg <= pwdata[PW-1:0];
                ADDR_W'(4*REG_H):  h_reg  <= pwdata[11:0];
                ADDR_W'(4*REG_TW): tw_reg <= pwdata[11:0];
                ADDR_W'(4*REG_TH): th_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_W'(4*REG_PX): prdata = 32'(px_reg);
            ADDR_W'(4*REG_PY): prdata = 32'(py_reg);
            ADDR_W'(4*REG_H):  prdata = 32'(h_reg);
            ADDR_W'(4*REG_TW): prdata = 32'(tw_reg);
            ADDR_W'(4*REG_TH): prdata = 32'(th_reg);
            default:           prdata = '0;
        endcase
    end

    // pipeline control: global enable, held by a waiting output item
    logic [LAT-1:0] v_reg;
    logic           adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], in_valid};
    end

    // stage A: select hit axis and form the distance numerator
    logic signed [DW-1:0] dh_a_reg, do_a_reg;
    logic signed [PW+2:0] num_a_reg;
    logic [PW-1:0]        poth_a_reg;
    logic [1:0]           tidx_a_reg;
    logic                 mir_a_reg;
    logic signed [DW-1:0] dh, dot;
    logic signed [PW+2:0] num_n;
    assign dh  = hit_side ? dir_y : dir_x;
    assign dot = hit_side ? dir_x : dir_y;
    always_comb
    begin
        num_n = $signed({3'b000, (hit_side ? cell_y : cell_x), {F{1'b0}}})
              - $signed({3'b000, (hit_side ? py_reg : px_reg)})
              + (dh[DW-1] ? $signed((PW+3)'(1) <<< F) : '0);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dh_a_reg   <= dh;
            do_a_reg   <= dot;
            num_a_reg  <= num_n;
            poth_a_reg <= hit_side ? px_reg : py_reg;
            tidx_a_reg <= hit_side ? (dir_y[DW-1] ? 2'd3 : 2'd1)
                                   : (dir_x[DW-1] ? 2'd0 : 2'd2);
            mir_a_reg  <= hit_side ? dir_y[DW-1] : (!dir_x[DW-1] && dir_x != '0);
        end
    end

    // stage B: magnitudes and special-case codes
    logic [N1-1:0] n1_b;
    logic [DW-1:0] d1_b;
    logic          zero_b, neg_b;
    logic [PW+2:0] nmag;
    logic [DW-1:0] dmag;
    assign nmag = num_a_reg[PW+2] ? (PW+3)'(0) - num_a_reg : num_a_reg;
    assign dmag = dh_a_reg[DW-1] ? -dh_a_reg : dh_a_reg;
    assign zero_b = dh_a_reg == '0;
    assign neg_b  = num_a_reg != '0 && (num_a_reg[PW+2] != dh_a_reg[DW-1]);
    // numerator may exceed PW bits; quotient then saturates anyway
    logic ovn_b;
    assign ovn_b = |nmag[PW+2:PW];
    assign n1_b = {nmag[PW-1:0], {F{1'b0}}};
    assign d1_b = zero_b ? DW'(1) : dmag;

    localparam int S1 = DW + PW + 2 + 3 + 1;
    logic [S1-1:0] s1_in, s1_out;
    assign s1_in = {do_a_reg, poth_a_reg, tidx_a_reg, mir_a_reg, zero_b, neg_b, ovn_b};
    logic [N1-1:0] q1;
    rwsp_div #(.NW(N1), .DW(DW), .SW(S1)) u_div1 (
        .clk(clk), .adv(adv), .num(n1_b), .den(d1_b),
        .side_in(s1_in), .quo(q1), .side_out(s1_out));

    // stage C: saturate distance, start line height divide
    logic signed [DW-1:0] do_c;
    logic [PW-1:0] poth_c;
    logic [1:0]    tidx_c;
    logic          mir_c, zero_c, neg_c, ovn_c;
    assign {do_c, poth_c, tidx_c, mir_c, zero_c, neg_c, ovn_c} = s1_out;
    logic [PW-1:0] perp_c;
    logic          f1_c;
    always_comb
    begin
        if (zero_c)
            perp_c = '1;
        else if (neg_c)
            perp_c = '0;
        else if (ovn_c || |q1[N1-1:PW])
            perp_c = '1;
        else
            perp_c = q1[PW-1:0];
        f1_c = zero_c || perp_c == '0;
    end

    logic [PW-1:0]        perp_d_reg;
    logic signed [DW-1:0] do_d_reg;
    logic [PW-1:0]        poth_d_reg;
    logic [1:0]           tidx_d_reg;
    logic                 mir_d_reg, f1_d_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            perp_d_reg <= perp_c;
            do_d_reg   <= do_c;
            poth_d_reg <= poth_c;
            tidx_d_reg <= tidx_c;
            mir_d_reg  <= mir_c;
            f1_d_reg   <= f1_c;
        end
    end

    localparam int S2 = PW + DW + PW + 2 + 1 + 1;
    logic [S2-1:0] s2_in, s2_out;
    logic [N2-1:0] q2;
    assign s2_in = {perp_d_reg, do_d_reg, poth_d_reg, tidx_d_reg, mir_d_reg, f1_d_reg};
    rwsp_div #(.NW(N2), .DW(PW), .SW(S2)) u_div2 (
        .clk(clk), .adv(adv), .num({h_reg, {F{1'b0}}}),
        .den(perp_d_reg == '0 ? PW'(1) : perp_d_reg),
        .side_in(s2_in), .quo(q2), .side_out(s2_out));

    // stage E: line height, rows, and the hit point product
    logic [PW-1:0]        perp_e;
    logic signed [DW-1:0] do_e;
    logic [PW-1:0]        poth_e;
    logic [1:0]           tidx_e;
    logic                 mir_e, f1_e;
    assign {perp_e, do_e, poth_e, tidx_e, mir_e, f1_e} = s2_out;
    logic [15:0] lh_e;
    assign lh_e = (perp_e == '0 || |q2[N2-1:16]) ? 16'hFFFF : q2[15:0];

    logic [15:0] lh_f_reg;
    logic [PW+DW-1:0] pm_f_reg;
    logic             dneg_f_reg;
    logic [PW-1:0]    poth_f_reg;
    logic [1:0]       tidx_f_reg;
    logic             mir_f_reg, f_f_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lh_f_reg   <= lh_e;
            pm_f_reg   <= perp_e * (do_e[DW-1] ? DW'(-do_e) : DW'(do_e));
            dneg_f_reg <= do_e[DW-1];
            poth_f_reg <= poth_e;
            tidx_f_reg <= tidx_e;
            mir_f_reg  <= mir_e;
            f_f_reg    <= f1_e;
        end
    end

    // stage G: hit fraction, rows
    logic [PW+DW-1:0] prod_g;
    logic [F-1:0]     frac_g;
    assign prod_g = dneg_f_reg ? -pm_f_reg : pm_f_reg;
    assign frac_g = poth_f_reg[F-1:0] + prod_g[2*F-1:F];

    logic [11:0] hh;
    logic [14:0] hl;
    logic [11:0] ds_g, de_g;
    assign hh = {1'b0, h_reg[11:1]};
    assign hl = lh_f_reg[15:1];
    always_comb
    begin
        ds_g = ({3'b000, hh} < hl) ? 12'd0 : 12'(hh - hl[11:0]);
        if ({4'b0, hh} + {1'b0, hl} >= {4'b0, h_reg})
            de_g = (h_reg == '0) ? 12'd0 : h_reg - 12'd1;
        else
            de_g = 12'(hh + hl[11:0]);
    end
    // offset: ds + hl - hh is 0 unless start was clamped to 0
    logic [14:0] off_g;
    assign off_g = ({3'b000, hh} < hl) ? hl - {3'b000, hh} : 15'd0;

    logic [F+11:0] fc_h_reg;
    logic [15:0]   lh_h_reg;
    logic [11:0]   ds_h_reg, de_h_reg;
    logic [14:0]   off_h_reg;
    logic [1:0]    tidx_h_reg;
    logic          mir_h_reg, f_h_reg;
    logic [PW-1:0] perp_h_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fc_h_reg   <= frac_g * tw_reg;
            lh_h_reg   <= lh_f_reg;
            ds_h_reg   <= ds_g;
            de_h_reg   <= de_g;
            off_h_reg  <= off_g;
            tidx_h_reg <= tidx_f_reg;
            mir_h_reg  <= mir_f_reg;
            f_h_reg    <= f_f_reg;
        end
    end
    // perpendicular distance rides along through the last divider
    logic [PW-1:0] perp_f_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            perp_f_reg <= perp_e;
            perp_h_reg <= perp_f_reg;
        end
    end

    logic [11:0] col_i;
    assign col_i = (tw_reg != '0 && mir_h_reg) ? tw_reg - fc_h_reg[F+11:F] - 12'd1
                                             : fc_h_reg[F+11:F];

    localparam int S3 = PW + 16 + 12 + 12 + 15 + 2 + 12 + 1;
    logic [S3-1:0] s3_in, s3_out;
    logic [N2-1:0] q3;
    assign s3_in = {perp_h_reg, lh_h_reg, ds_h_reg, de_h_reg, off_h_reg, tidx_h_reg,
                    col_i, f_h_reg};
    rwsp_div #(.NW(N2), .DW(16), .SW(S3)) u_div3 (
        .clk(clk), .adv(adv), .num({th_reg, {F{1'b0}}}),
        .den(lh_h_reg == '0 ? 16'd1 : lh_h_reg),
        .side_in(s3_in), .quo(q3), .side_out(s3_out));

    logic [PW-1:0] perp_k;
    logic [15:0]   lh_k;
    logic [11:0]   ds_k, de_k, col_k;
    logic [14:0]   off_k;
    logic [1:0]    tidx_k;
    logic          f_k;
    logic [TW-1:0] step_k;
    assign {perp_k, lh_k, ds_k, de_k, off_k, tidx_k, col_k, f_k} = s3_out;
    assign step_k = (lh_k == '0) ? '1 : q3;

    logic [PW-1:0] perp_l_reg;
    logic [15:0]   lh_l_reg;
    logic [11:0]   ds_l_reg, de_l_reg, col_l_reg;
    logic [1:0]    tidx_l_reg;
    logic          f_l_reg;
    logic [TW-1:0] step_l_reg;
    logic [TW+14:0] ts_l_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            perp_l_reg <= perp_k;
            lh_l_reg   <= lh_k;
            ds_l_reg   <= ds_k;
            de_l_reg   <= de_k;
            col_l_reg  <= col_k;
            tidx_l_reg <= tidx_k;
            f_l_reg    <= f_k || lh_k == '0;
            step_l_reg <= step_k;
            ts_l_reg   <= off_k * step_k;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wall_distance  <= perp_l_reg;
            slice_rows     <= lh_l_reg;
            row_first      <= ds_l_reg;
            row_last       <= de_l_reg;
            texture_index  <= tidx_l_reg;
            texture_column <= col_l_reg;
            texture_step   <= step_l_reg;
            texture_start  <= |ts_l_reg[TW+14:TW] ? '1 : ts_l_reg[TW-1:0];
            divide_flag    <= f_l_reg;
        end
    end
endmodule
